FILE: hdl/bone_global_transform_assert.svh
// Assertion macros used by the checker file.
`ifndef BONE_GLOBAL_TRANSFORM_ASSERT_SVH
`define BONE_GLOBAL_TRANSFORM_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BGT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BGT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/bgt_pkg.sv
package bgt_pkg;
    localparam int MaxBones    = 64;
    localparam int IdxW        = $clog2(MaxBones);
    localparam int CordicSteps = 16;
    localparam int StepW       = $clog2(CordicSteps + 1);
    localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd2097152;
            5'd1:  v = 34'sd1238021;
            5'd2:  v = 34'sd654136;
            5'd3:  v = 34'sd332050;
            5'd4:  v = 34'sd166669;
            5'd5:  v = 34'sd83416;
            5'd6:  v = 34'sd41718;
            5'd7:  v = 34'sd20860;
            5'd8:  v = 34'sd10430;
            5'd9:  v = 34'sd5215;
            5'd10: v = 34'sd2608;
            5'd11: v = 34'sd1304;
            5'd12: v = 34'sd652;
            5'd13: v = 34'sd326;
            5'd14: v = 34'sd163;
            5'd15: v = 34'sd81;
            5'd16: v = 34'sd41;
            5'd17: v = 34'sd20;
            5'd18: v = 34'sd10;
            5'd19: v = 34'sd5;
            5'd20: v = 34'sd3;
            5'd21: v = 34'sd1;
            5'd22: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) r = 32'sh7fffffff;
        else if (v < -66'sd2147483648) r = 32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    typedef struct packed {
        logic                start;
        logic signed [31:0]  op_a;
        logic signed [33:0]  op_b;
        logic [4:0]          shift;
    } t_mul_req;
endpackage

FILE: hdl/bgt_cordic.sv
module bgt_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;
    t_state r_state;
    logic signed [33:0] r_x, r_y, r_z;
    logic [1:0] r_q;
    logic [bgt_pkg::StepW-1:0] r_i;
    logic [1:0] w_q;
    logic [15:0] w_res;

    assign w_q   = 2'((i_angle + 16'h2000) >> 14);
    assign w_res = i_angle - {w_q, 14'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x <= bgt_pkg::CordicGain;
                        r_y <= '0;
                        r_z <= 34'(signed'(w_res)) <<< 8;
                        r_q <= w_q;
                        r_i <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    // Arithmetic shift is floor division by a power of two.
                    if (r_z >= 0) begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - bgt_pkg::atan_lut(5'(r_i));
                    end else begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + bgt_pkg::atan_lut(5'(r_i));
                    end
                    if (r_i == bgt_pkg::LastStep) r_state <= S_FIN;
                    r_i <= r_i + 1'b1;
                end
                S_FIN: begin
                    case (r_q)
                        2'd0: begin o_cos <= r_x;  o_sin <= r_y;  end
                        2'd1: begin o_cos <= -r_y; o_sin <= r_x;  end
                        2'd2: begin o_cos <= -r_x; o_sin <= -r_y; end
                        default: begin o_cos <= r_y; o_sin <= -r_x; end
                    endcase
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: hdl/bgt_mul.sv
module bgt_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgt_pkg::t_mul_req  i_req,
    output logic               o_done,
    output logic signed [65:0] o_prod
);
    // Multiply: product registered, then floor shift.
    logic               r_v;
    logic signed [65:0] r_p;
    logic [4:0]         r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r_v    <= i_req.start;
            o_done <= r_v;
        end
        r_p    <= 66'(i_req.op_a) * 66'(i_req.op_b);
        r_sh   <= i_req.shift;
        o_prod <= r_p >>> r_sh;
    end
endmodule

FILE: hdl/bone_global_transform.sv
// Global transform of one bone per item, items sent parent first.
// Input channel: i_valid with o_stall; the item is taken when valid is high
// and stall is low. Output channel: o_valid with i_stall, one result item per
// input item, held steady while stalled.
// Each item passes through store read, setup and output, two CORDIC runs
// on one shared rotator, and products on one shared multiplier (four
// matrix products, four more for a child's translation and two for the
// inherited scales).
// o_stall stays high while an item is in work or its result waits to be
// taken, so the block takes no new item until the result of the last one
// has been taken.
// The transform store is one 64-entry memory, undefined after reset;
// a parent slot must have been written before it is used.
// Reset clears the sequencer and the output valid only.
// A stalled receiver holds the result and blocks new items.
module bone_global_transform (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [5:0]  i_bone_index,
    input  logic [5:0]  i_parent_index,
    input  logic        i_has_parent,
    input  logic        i_inherit_rotation,
    input  logic        i_inherit_scale,
    input  logic signed [31:0] i_local_x,
    input  logic signed [31:0] i_local_y,
    input  logic [15:0] i_local_skew_x,
    input  logic [15:0] i_local_skew_y,
    input  logic signed [31:0] i_local_scale_x,
    input  logic signed [31:0] i_local_scale_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_out_bone_index,
    output logic signed [31:0] o_mat_a,
    output logic signed [31:0] o_mat_b,
    output logic signed [31:0] o_mat_c,
    output logic signed [31:0] o_mat_d,
    output logic signed [31:0] o_mat_tx,
    output logic signed [31:0] o_mat_ty,
    output logic [15:0] o_world_skew_x,
    output logic [15:0] o_world_skew_y,
    output logic signed [31:0] o_world_scale_x,
    output logic signed [31:0] o_world_scale_y
);
    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_LOAD, S_TXA, S_TXB, S_TYA, S_TYB, S_SCX, S_SCY,
        S_COSX, S_COSY, S_MA, S_MB, S_MC, S_MD, S_OUT
    } t_state;
    typedef struct packed {
        logic signed [31:0] a, b, c, d, tx, ty;
        logic [15:0]        kx, ky;
        logic signed [31:0] sx, sy;
    } t_xf;

    t_state r_state;
    t_xf mem [bgt_pkg::MaxBones];
    t_xf r_par, r_cur;
    logic [5:0] r_bi, r_pi;
    logic r_hasp, r_irot, r_iscl, r_busy;
    logic signed [31:0] r_lx, r_ly;
    logic signed [65:0] r_acc;
    logic signed [33:0] r_cx, r_snx;
    bgt_pkg::t_mul_req  n_req;
    logic m_done, c_done, c_start;
    logic signed [65:0] m_prod;
    logic signed [33:0] c_cos, c_sin;
    logic [15:0] c_ang;

    bgt_mul u_mul (.i_clk, .i_rst_n, .i_req(n_req), .o_done(m_done), .o_prod(m_prod));
    bgt_cordic u_cordic (.i_clk, .i_rst_n, .i_start(c_start), .i_angle(c_ang),
                         .o_done(c_done), .o_cos(c_cos), .o_sin(c_sin));

    // A waiting result blocks the input as well.
    assign o_stall = (r_state != S_IDLE) || o_valid;

    // Each multiply or CORDIC state issues on entry, marked by r_busy low.
    always_comb begin
        n_req = '0;
        c_start = 1'b0;
        c_ang = r_cur.kx;
        if (!r_busy) begin
            case (r_state)
                S_TXA: n_req = '{1'b1, r_par.a, 34'(r_lx), 5'd16};
                S_TXB: n_req = '{1'b1, r_par.c, 34'(r_ly), 5'd16};
                S_TYA: n_req = '{1'b1, r_par.d, 34'(r_ly), 5'd16};
                S_TYB: n_req = '{1'b1, r_par.b, 34'(r_lx), 5'd16};
                S_SCX: n_req = '{1'b1, r_cur.sx, 34'(r_par.sx), 5'd16};
                S_SCY: n_req = '{1'b1, r_cur.sy, 34'(r_par.sy), 5'd16};
                S_COSX: c_start = 1'b1;
                S_COSY: begin c_start = 1'b1; c_ang = r_cur.ky; end
                S_MA: n_req = '{1'b1, r_cur.sx, c_cos, 5'd30};
                S_MB: n_req = '{1'b1, r_cur.sx, c_sin, 5'd30};
                // The sign goes on the sine so that the most negative scale stays exact.
                S_MC: n_req = '{1'b1, r_cur.sy, -r_snx, 5'd30};
                S_MD: n_req = '{1'b1, r_cur.sy, r_cx, 5'd30};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (n_req.start || c_start) r_busy <= 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (o_valid && !i_stall) o_valid <= 1'b0;
                    if (i_valid && !o_stall) begin
                        r_bi <= i_bone_index; r_pi <= i_parent_index;
                        r_hasp <= i_has_parent; r_irot <= i_inherit_rotation;
                        r_iscl <= i_inherit_scale;
                        r_lx <= i_local_x; r_ly <= i_local_y;
                        r_cur <= '{32'sd0, 32'sd0, 32'sd0, 32'sd0, i_local_x, i_local_y,
                                   i_local_skew_x, i_local_skew_y,
                                   i_local_scale_x, i_local_scale_y};
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_par <= mem[r_pi];
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_hasp) begin
                        if (r_irot) begin
                            r_cur.kx <= r_cur.kx + r_par.kx;
                            r_cur.ky <= r_cur.ky + r_par.ky;
                        end
                        r_state <= S_TXA;
                    end else begin
                        r_state <= S_COSX;
                    end
                end
                S_TXA: if (m_done) begin r_acc <= m_prod; r_busy <= 1'b0; r_state <= S_TXB; end
                S_TXB: if (m_done) begin
                    r_cur.tx <= bgt_pkg::sat32(r_acc + m_prod + 66'(r_par.tx));
                    r_busy <= 1'b0; r_state <= S_TYA;
                end
                S_TYA: if (m_done) begin r_acc <= m_prod; r_busy <= 1'b0; r_state <= S_TYB; end
                S_TYB: if (m_done) begin
                    r_cur.ty <= bgt_pkg::sat32(r_acc + m_prod + 66'(r_par.ty));
                    r_busy <= 1'b0;
                    r_state <= r_iscl ? S_SCX : S_COSX;
                end
                S_SCX: if (m_done) begin
                    r_cur.sx <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_SCY;
                end
                S_SCY: if (m_done) begin
                    r_cur.sy <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_COSX;
                end
                S_COSX: if (c_done) begin
                    r_cx <= c_cos; r_snx <= c_sin; r_busy <= 1'b0; r_state <= S_COSY;
                end
                S_COSY: if (c_done) begin r_busy <= 1'b0; r_state <= S_MA; end
                S_MA: if (m_done) begin
                    r_cur.a <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_MB;
                end
                S_MB: if (m_done) begin
                    r_cur.b <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_MC;
                end
                S_MC: if (m_done) begin
                    r_cur.c <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_MD;
                end
                S_MD: if (m_done) begin
                    r_cur.d <= bgt_pkg::sat32(m_prod); r_busy <= 1'b0; r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_out_bone_index <= r_bi;
                    o_mat_a <= r_cur.a; o_mat_b <= r_cur.b;
                    o_mat_c <= r_cur.c; o_mat_d <= r_cur.d;
                    o_mat_tx <= r_cur.tx; o_mat_ty <= r_cur.ty;
                    o_world_skew_x <= r_cur.kx; o_world_skew_y <= r_cur.ky;
                    o_world_scale_x <= r_cur.sx; o_world_scale_y <= r_cur.sy;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) mem[r_bi] <= r_cur;
    end
endmodule

FILE: hdl/bgt_checker.sv
`include "bone_global_transform_assert.svh"
module bgt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [5:0] o_out_bone_index
);
    `BGT_ASSERT_NEXT(a_acc_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "busy expected")
    `BGT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_out_bone_index), "output changed while stalled")
    `BGT_ASSERT_NEXT(a_no_out_soon, i_clk, i_rst_n, i_valid && !o_stall, !$rose(o_valid),
                     "result too early")
    `BGT_ASSERT_IMP(a_rise_busy, i_clk, i_rst_n, $rose(o_valid), $past(o_stall), "result without item")
    `BGT_ASSERT_IMP(a_out_blocks, i_clk, i_rst_n, o_valid, o_stall, "input open while result waits")
endmodule

bind bone_global_transform bgt_checker u_bgt_checker (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall,
    .o_out_bone_index
);

FILE: tb/sv/bone_global_transform_tb.sv
`timescale 1ns / 100ps

module bone_global_transform_tb;

    typedef struct packed {
        logic [5:0]         bone;
        logic [5:0]         parent;
        logic               has_parent;
        logic               inh_rot;
        logic               inh_scl;
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic [15:0]        kx;
        logic [15:0]        ky;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } bone_in_t;

    typedef struct packed {
        logic [5:0]         bone;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic [15:0]        kx;
        logic [15:0]        ky;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } bone_out_t;

    localparam int NumRandom = 1500;
    localparam int MaxGap    = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    bone_in_t    drv;
    logic        o_valid;
    logic        i_stall;
    wire bone_out_t mon;

    bone_global_transform u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_bone_index       (drv.bone),
        .i_parent_index     (drv.parent),
        .i_has_parent       (drv.has_parent),
        .i_inherit_rotation (drv.inh_rot),
        .i_inherit_scale    (drv.inh_scl),
        .i_local_x          (drv.lx),
        .i_local_y          (drv.ly),
        .i_local_skew_x     (drv.kx),
        .i_local_skew_y     (drv.ky),
        .i_local_scale_x    (drv.sx),
        .i_local_scale_y    (drv.sy),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_bone_index   (mon.bone),
        .o_mat_a            (mon.a),
        .o_mat_b            (mon.b),
        .o_mat_c            (mon.c),
        .o_mat_d            (mon.d),
        .o_mat_tx           (mon.tx),
        .o_mat_ty           (mon.ty),
        .o_world_skew_x     (mon.kx),
        .o_world_skew_y     (mon.ky),
        .o_world_scale_x    (mon.sx),
        .o_world_scale_y    (mon.sy)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Predictor copy of the transform store.
    bone_out_t   world_store [64];
    bit          slot_written [64];
    bone_out_t   pending_world [$];
    int          error_count;
    int          results_seen;
    int          parented_seen;
    bit          hold_receiver;

    function automatic logic signed [31:0] clamp32(input logic signed [95:0] v);
        if (v > 96'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -96'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Arithmetic shift on a signed value is a floor division.
    function automatic logic signed [31:0] scaled_product(input logic signed [47:0] p,
                                                          input logic signed [47:0] q,
                                                          input int sh);
        logic signed [95:0] prod;
        prod = p * q;
        return clamp32(prod >>> sh);
    endfunction

    function automatic void rotate_angle(input logic [15:0] ang,
                                         output logic signed [47:0] co,
                                         output logic signed [47:0] si);
        logic [1:0]         quad;
        logic [15:0]        resid;
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic signed [47:0] z;
        logic signed [47:0] dx;
        logic signed [47:0] dy;
        logic signed [47:0] atv;
        quad  = 2'((17'(ang) + 17'h2000) >> 14);
        resid = ang - 16'(quad) * 16'h4000;
        x = 48'sd652032874;
        y = 0;
        z = 48'($signed(resid)) * 256;
        for (int i = 0; i < bgt_pkg::CordicSteps; i++) begin
            atv = 48'(bgt_pkg::atan_lut(5'(i)));
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atv;
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atv;
            end
        end
        case (quad)
            2'd0: begin co = x; si = y; end
            2'd1: begin co = -y; si = x; end
            2'd2: begin co = -x; si = -y; end
            default: begin co = y; si = -x; end
        endcase
    endfunction

    function automatic bone_out_t compute_world(input bone_in_t it);
        bone_out_t          r;
        bone_out_t          par;
        logic signed [95:0] acc;
        logic signed [47:0] sx;
        logic signed [47:0] sy;
        logic signed [47:0] cx;
        logic signed [47:0] snx;
        logic signed [47:0] cy;
        logic signed [47:0] sny;
        r.bone = it.bone;
        r.kx = it.kx;
        r.ky = it.ky;
        sx = it.sx;
        sy = it.sy;
        if (it.has_parent) begin
            par = world_store[it.parent];
            acc = ((96'(par.a) * it.lx) >>> 16) + ((96'(par.c) * it.ly) >>> 16) + par.tx;
            r.tx = clamp32(acc);
            acc = ((96'(par.d) * it.ly) >>> 16) + ((96'(par.b) * it.lx) >>> 16) + par.ty;
            r.ty = clamp32(acc);
            if (it.inh_rot) begin
                r.kx = it.kx + par.kx;
                r.ky = it.ky + par.ky;
            end
            if (it.inh_scl) begin
                sx = scaled_product(sx, par.sx, 16);
                sy = scaled_product(sy, par.sy, 16);
            end
        end else begin
            r.tx = it.lx;
            r.ty = it.ly;
        end
        rotate_angle(r.kx, cx, snx);
        rotate_angle(r.ky, cy, sny);
        r.a = scaled_product(sx, cy, 30);
        r.b = scaled_product(sx, sny, 30);
        r.c = scaled_product(-sy, snx, 30);
        r.d = scaled_product(sy, cx, 30);
        r.sx = sx[31:0];
        r.sy = sy[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Offers one item until it is taken, then idles for the gap it is given.
    task automatic send_bone(input bone_in_t it, input int gap);
        bone_out_t exp_out;
        i_valid <= 1'b1;
        drv <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_out = compute_world(it);
        pending_world = {pending_world, exp_out};
        world_store[it.bone] = exp_out;
        slot_written[it.bone] = 1'b1;
        if (it.has_parent) parented_seen++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [5:0] written_slot();
        logic [5:0] s;
        do s = 6'($urandom); while (!slot_written[s]);
        return s;
    endfunction

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return 32'($urandom);
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return 32'($signed(17'($urandom))) <<< $urandom_range(0, 4);
        endcase
    endfunction

    function automatic bone_in_t rand_bone(input bit rooted);
        bone_in_t it;
        it.bone = 6'($urandom);
        it.has_parent = rooted ? 1'b0 : 1'b1;
        it.parent = rooted ? 6'($urandom) : written_slot();
        it.inh_rot = 1'($urandom);
        it.inh_scl = 1'($urandom);
        it.lx = rand_q16();
        it.ly = rand_q16();
        it.kx = 16'($urandom);
        it.ky = 16'($urandom);
        it.sx = ($urandom_range(0, 3) == 0) ? rand_q16() : 32'($signed(18'($urandom)));
        it.sy = ($urandom_range(0, 3) == 0) ? rand_q16() : 32'($signed(18'($urandom)));
        return it;
    endfunction

    // Receiver side: stalls for a randomly drawn wait, then takes one item.
    initial begin
        bone_out_t want;
        int        wait_cycles;
        i_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_receiver) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            wait_cycles = $urandom_range(0, MaxGap);
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(posedge i_clk);
            end while (!o_valid);
            results_seen++;
            if (pending_world.size() == 0) begin
                report_mismatch("unexpected item", 32'(mon.bone), 0);
            end else begin
                want = pending_world.pop_front();
                if (mon.bone !== want.bone) report_mismatch("bone", 32'(mon.bone), 32'(want.bone));
                if (mon.a !== want.a) report_mismatch("mat_a", mon.a, want.a);
                if (mon.b !== want.b) report_mismatch("mat_b", mon.b, want.b);
                if (mon.c !== want.c) report_mismatch("mat_c", mon.c, want.c);
                if (mon.d !== want.d) report_mismatch("mat_d", mon.d, want.d);
                if (mon.tx !== want.tx) report_mismatch("mat_tx", mon.tx, want.tx);
                if (mon.ty !== want.ty) report_mismatch("mat_ty", mon.ty, want.ty);
                if (mon.kx !== want.kx) report_mismatch("skew_x", 32'(mon.kx), 32'(want.kx));
                if (mon.ky !== want.ky) report_mismatch("skew_y", 32'(mon.ky), 32'(want.ky));
                if (mon.sx !== want.sx) report_mismatch("scale_x", mon.sx, want.sx);
                if (mon.sy !== want.sy) report_mismatch("scale_y", mon.sy, want.sy);
            end
        end
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Directed rows; only the identity root has its translation typed in.
    bone_in_t  directed_rows [$];
    bone_out_t identity_root;

    task automatic add_row(input bone_in_t row);
        directed_rows = {directed_rows, row};
    endtask

    initial begin
        bone_in_t it;
        int       gap;
        error_count = 0;
        results_seen = 0;
        parented_seen = 0;
        hold_receiver = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        drv = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Root, zero skew, unit scale: a = d = 1.0 within CORDIC error.
        add_row('{6'd0, 6'd0, 1'b0, 1'b0, 1'b0, 32'sh00010000,
            -32'sh00020000, 16'h0000, 16'h0000, 32'sh00010000, 32'sh00010000});
        add_row('{6'd63, 6'd63, 1'b0, 1'b1, 1'b1, 32'sh7fffffff,
            32'sh80000000, 16'hffff, 16'h4000, 32'sh7fffffff, 32'sh80000000});
        add_row('{6'd1, 6'd0, 1'b1, 1'b1, 1'b1, 32'sh00030000,
            32'sh00040000, 16'h2000, 16'hc000, 32'sh00020000, 32'sh00008000});
        add_row('{6'd2, 6'd63, 1'b1, 1'b1, 1'b1, 32'sh7fffffff,
            32'sh7fffffff, 16'h8000, 16'h1fff, 32'sh80000000, 32'sh7fffffff});
        add_row('{6'd3, 6'd1, 1'b1, 1'b0, 1'b0, 32'sh80000000,
            32'sh80000000, 16'h6000, 16'he000, 32'sh00010000, 32'shffff0000});
        // Parent equal to self uses the old contents of the slot.
        add_row('{6'd1, 6'd1, 1'b1, 1'b1, 1'b0, 32'sh00000001,
            32'shffffffff, 16'h2001, 16'ha000, 32'sh00010000, 32'sh00010000});
        add_row('{6'd4, 6'd2, 1'b1, 1'b0, 1'b1, 32'sh12345678,
            32'shedcba987, 16'h5fff, 16'h9fff, 32'sh00000000, 32'shfffffffe});
        for (int i = 0; i < directed_rows.size(); i++) begin
            send_bone(directed_rows[i], i % 3);
        end
        identity_root = world_store[0];
        if (identity_root.tx !== 32'sh00010000 || identity_root.ty !== -32'sh00020000)
            report_mismatch("identity root tx", identity_root.tx, 32'sh00010000);

        for (int n = 0; n < NumRandom; n++) begin
            it = rand_bone($urandom_range(0, 5) == 0);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MaxGap);
            if (n == 400) hold_receiver = 1'b1;
            if (n == 900) begin
                // Pause the sender until the block has drained.
                i_valid <= 1'b0;
                while (pending_world.size() != 0) @(posedge i_clk);
            end
            send_bone(it, (n >= 400 && n < 420) ? 0 : gap);
        end
        i_valid <= 1'b0;

        while (pending_world.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d bones, %0d of them parented, %0d results checked.",
                 directed_rows.size() + NumRandom, parented_seen, results_seen);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
